>>> hdl/maf_pkg.sv
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared constants, queue entry and status types, and state encodings.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 16;
  localparam int CFG_BITS    = 7;
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_BITS-1:0] WL_RESET = CFG_BITS'(10);

  // Work handed from the front end to the divider.
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0]        count;
    logic                       full;
  } maf_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } maf_qstat_t;

  typedef enum logic {
    FR_IDLE,
    FR_UPD
  } maf_front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } maf_back_state_e;

endpackage

>>> hdl/maf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/maf_fifo.sv
// ----------------------------------------------------------------------------
// Moving average hand-off queue
// Short register queue between the front end and the divider.
// ----------------------------------------------------------------------------
module maf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  maf_pkg::maf_entry_t data_i,
  input  logic                pop_i,
  output maf_pkg::maf_entry_t data_o,
  output maf_pkg::maf_qstat_t stat_o
);

  maf_pkg::maf_entry_t mem_q [maf_pkg::QUEUE_DEPTH];
  logic [maf_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [maf_pkg::QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [maf_pkg::QCNT_BITS-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == maf_pkg::QCNT_BITS'(maf_pkg::QUEUE_DEPTH));
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (int'(wr_ptr_q) == maf_pkg::QUEUE_DEPTH - 1) ? '0
               : wr_ptr_q + maf_pkg::QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == maf_pkg::QUEUE_DEPTH - 1) ? '0
               : rd_ptr_q + maf_pkg::QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + maf_pkg::QCNT_BITS'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - maf_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/maf_front.sv
// ----------------------------------------------------------------------------
// Moving average front end
// Takes samples, keeps the sample ring, running sum, count and write slot,
// and hands sum and count to the divider queue.
// ----------------------------------------------------------------------------
module maf_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [maf_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  maf_pkg::maf_qstat_t                   qstat_i,
  output logic                                  q_push_o,
  output maf_pkg::maf_entry_t                   q_data_o
);

  maf_pkg::maf_front_state_e state_q, state_d;

  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample_q;
  logic signed [maf_pkg::SUM_BITS-1:0]    sum_q, sum_d;
  logic [maf_pkg::CNT_BITS-1:0]           cnt_q, cnt_d;
  logic [maf_pkg::CNT_BITS-1:0]           len_q, len_d;
  logic [maf_pkg::SLOT_BITS-1:0]          slot_q, slot_d;
  logic [maf_pkg::CNT_BITS-1:0]           slot_inc;
  logic [maf_pkg::SAMPLE_BITS-1:0]        old_sample;
  logic signed [maf_pkg::SUM_BITS-1:0]    old_ext, new_ext;
  logic accept, cfg_write, ram_re, ram_we, win_full;

  maf_ram #(
    .WIDTH (maf_pkg::SAMPLE_BITS),
    .DEPTH (maf_pkg::MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (old_sample)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      maf_pkg::FR_IDLE: begin
        if (accept) begin
          state_d = maf_pkg::FR_UPD;
        end
      end
      maf_pkg::FR_UPD: begin
        state_d = maf_pkg::FR_IDLE;
      end
      default: state_d = maf_pkg::FR_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    full      = 1'b1;
    cfg_ready = 1'b0;
    ram_we    = 1'b0;
    q_push_o  = 1'b0;
    unique case (state_q)
      maf_pkg::FR_IDLE: begin
        full      = qstat_i.full;
        cfg_ready = 1'b1;
      end
      maf_pkg::FR_UPD: begin
        ram_we   = 1'b1;
        q_push_o = 1'b1;
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  assign accept    = push && !full;
  assign ram_re    = accept;
  assign cfg_write = cfg_valid && cfg_ready;

  // Window length as used: zero counts as one, large values clamp.
  always_comb begin
    if (cfg_data_i == '0) begin
      len_d = maf_pkg::CNT_BITS'(1);
    end else if (int'(cfg_data_i) > maf_pkg::MAX_WINDOW) begin
      len_d = maf_pkg::CNT_BITS'(maf_pkg::MAX_WINDOW);
    end else begin
      len_d = maf_pkg::CNT_BITS'(cfg_data_i);
    end
  end

  assign win_full = (cnt_q >= len_q);
  assign old_ext  = win_full ? maf_pkg::SUM_BITS'(signed'(old_sample)) : '0;
  assign new_ext  = maf_pkg::SUM_BITS'(sample_q);
  assign sum_d    = sum_q - old_ext + new_ext;
  assign cnt_d    = win_full ? cnt_q : cnt_q + maf_pkg::CNT_BITS'(1);
  assign slot_inc = maf_pkg::CNT_BITS'(slot_q) + maf_pkg::CNT_BITS'(1);
  assign slot_d   = (slot_inc >= len_q) ? '0 : maf_pkg::SLOT_BITS'(slot_inc);

  assign q_data_o.sum   = sum_d;
  assign q_data_o.count = cnt_d;
  assign q_data_o.full  = (cnt_d == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= maf_pkg::FR_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      slot_q  <= '0;
      len_q   <= maf_pkg::CNT_BITS'(maf_pkg::WL_RESET);
    end else begin
      state_q <= state_d;
      if (cfg_write) begin
        len_q  <= len_d;
        sum_q  <= '0;
        cnt_q  <= '0;
        slot_q <= '0;
      end else if (state_q == maf_pkg::FR_UPD) begin
        sum_q  <= sum_d;
        cnt_q  <= cnt_d;
        slot_q <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

endmodule

>>> hdl/maf_back.sv
// ----------------------------------------------------------------------------
// Moving average back end
// Bit-serial restoring divider of sum by count, result held until popped.
// ----------------------------------------------------------------------------
module maf_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  maf_pkg::maf_qstat_t                 qstat_i,
  input  maf_pkg::maf_entry_t                 q_data_i,
  output logic                                q_pop_o,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [maf_pkg::OUT_BITS-1:0] average_o,
  output logic                                window_full_o
);

  maf_pkg::maf_back_state_e state_q, state_d;

  logic [maf_pkg::CNT_BITS-1:0]  rem_q, rem_d;
  logic [maf_pkg::CNT_BITS-1:0]  div_q;
  logic [maf_pkg::SUM_BITS-1:0]  quo_q, quo_d;
  logic [maf_pkg::STEP_BITS-1:0] step_q;
  logic                          neg_q, flag_q;
  logic [maf_pkg::OUT_BITS-1:0]  avg_q;
  logic [maf_pkg::CNT_BITS:0]    trial;
  logic                          ge, load, last;
  logic [maf_pkg::SUM_BITS-1:0]  mag;
  logic [maf_pkg::SUM_BITS-1:0]  signed_quo;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      maf_pkg::BK_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = maf_pkg::BK_DIV;
        end
      end
      maf_pkg::BK_DIV: begin
        if (last) begin
          state_d = maf_pkg::BK_HOLD;
        end
      end
      maf_pkg::BK_HOLD: begin
        if (pop) begin
          state_d = maf_pkg::BK_IDLE;
        end
      end
      default: state_d = maf_pkg::BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop_o = 1'b0;
    empty   = 1'b1;
    unique case (state_q)
      maf_pkg::BK_IDLE: q_pop_o = !qstat_i.empty;
      maf_pkg::BK_DIV:  q_pop_o = 1'b0;
      maf_pkg::BK_HOLD: empty   = 1'b0;
      default:          empty   = 1'b1;
    endcase
  end

  assign load = q_pop_o;
  assign last = (step_q == '0);

  // One quotient bit per cycle; remainder stays below the divisor.
  assign trial = {rem_q, quo_q[maf_pkg::SUM_BITS-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign rem_d = ge ? maf_pkg::CNT_BITS'(trial - {1'b0, div_q})
                    : maf_pkg::CNT_BITS'(trial);
  assign quo_d = {quo_q[maf_pkg::SUM_BITS-2:0], ge};

  assign mag        = q_data_i.sum[maf_pkg::SUM_BITS-1] ? -q_data_i.sum : q_data_i.sum;
  assign signed_quo = neg_q ? -quo_d : quo_d;

  assign average_o     = avg_q;
  assign window_full_o = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= maf_pkg::BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        step_q <= maf_pkg::STEP_BITS'(maf_pkg::DIV_STEPS - 1);
      end else if (state_q == maf_pkg::BK_DIV && !last) begin
        step_q <= step_q - maf_pkg::STEP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= '0;
      quo_q  <= mag;
      div_q  <= q_data_i.count;
      neg_q  <= q_data_i.sum[maf_pkg::SUM_BITS-1];
      flag_q <= q_data_i.full;
    end else if (state_q == maf_pkg::BK_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (last) begin
        avg_q <= signed_quo[maf_pkg::OUT_BITS-1:0];
      end
    end
  end

endmodule

>>> hdl/moving_average_filter_top.sv
// ----------------------------------------------------------------------------
// Moving average filter
// Boxcar average of the most recent signed samples, one result per sample.
// ----------------------------------------------------------------------------
// Each sample yields one result. The back end's bit-serial divider works one
// quotient bit per cycle over the 22-bit running sum after loading an entry
// from the queue, and takes the next entry only once its result is popped.
// The front end reads the old sample when it takes a push, writes the ring
// in its update state and runs ahead through a two-entry queue, so pushes
// are taken while a finished result waits to be popped. Writing the
// window length, only while the front end is idle, restarts the fill: the
// average is taken over the samples seen so far until the window is full.
// ----------------------------------------------------------------------------
module moving_average_filter_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [maf_pkg::OUT_BITS-1:0]    average_o,
  output logic                                  window_full_o,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [maf_pkg::CFG_BITS-1:0]          cfg_data_i
);

  maf_pkg::maf_qstat_t qstat;
  maf_pkg::maf_entry_t q_wdata, q_rdata;
  logic q_push, q_pop;

  maf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .sample_i   (sample_i),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data_i),
    .qstat_i    (qstat),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  maf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (qstat)
  );

  maf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .average_o     (average_o),
    .window_full_o (window_full_o)
  );

endmodule

>>> hdl/maf_checker.sv
// ----------------------------------------------------------------------------
// Moving average filter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module maf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic signed [maf_pkg::OUT_BITS-1:0] average_o,
  input logic                               window_full_o,
  input logic                               cfg_ready
);

  // Front end is busy updating the ring right after taking a request.
  a_busy_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("full not raised after accepted request");

  // A popped result is not shown again right after the pop.
  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty |=> empty)
    else $error("result shown again right after pop");

  // No config write is taken while the front end is mid-update.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> !cfg_ready)
    else $error("config ready while sample update in flight");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(average_o) && $stable(window_full_o))
    else $error("waiting result changed before pop");

endmodule

bind moving_average_filter_top maf_checker u_maf_checker (.*);
